/* hdl/size_class_pool_allocator_core_macros.svh */
// Assertion macros used by the allocator core.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

  localparam int unsigned GRANULE     = 8;
  localparam int unsigned NUM_CLASSES = 16;
  localparam int unsigned CLASS_W     = 4;
  localparam int unsigned LINK_AW     = 13;
  localparam int unsigned LINK_DEPTH  = 8192;
  localparam logic [16:0] HEAP_BYTES  = 17'h10000;
  localparam logic [15:0] MAX_BLOCK   = 16'd128;

  localparam logic [2:0] ST_ALLOC = 3'd0;
  localparam logic [2:0] ST_FREED = 3'd1;
  localparam logic [2:0] ST_NULL  = 3'd2;
  localparam logic [2:0] ST_BIG   = 3'd3;
  localparam logic [2:0] ST_OOM   = 3'd4;

  localparam logic [1:0] REG_HEAP_START   = 2'd0;
  localparam logic [1:0] REG_HEAP_END     = 2'd1;
  localparam logic [1:0] REG_REFILL_COUNT = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] size_bytes;
    logic [15:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] block_addr;
    logic [16:0] claimed_bytes;
  } out_item_t;

  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] waddr;
    logic [15:0]        wdata;
    logic               re;
    logic [LINK_AW-1:0] raddr;
  } lm_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_REF0,
    S_GROW,
    S_SRCH,
    S_STEAL,
    S_FIT,
    S_LINK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* hdl/scpa_link_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module scpa_link_mem (
  input  wire logic             clk,
  input  wire scpa_pkg::lm_req_t req,
  output logic [15:0]           rdata
);

  logic [15:0] mem [scpa_pkg::LINK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/size_class_pool_allocator_core.sv */
// Size-class pool allocator for small blocks (16 classes of 8-byte granules).
// Input channel in_valid / in_stall / in_item carries allocate or free requests;
// a transfer happens at a rising edge with in_valid high and in_stall low.
// Each request yields exactly one result on out_valid / out_stall / out_item
// (status, block address, bytes claimed from the heap window so far).
// Requests are handled one at a time. A free or an oversized or null request
// goes from decode straight to the result; an allocate that hits its class
// list pops its head from the link memory. A refill either grows the pool
// from the heap window or carves blocks from an existing pool, which may be
// a block taken from a larger list after scanning the larger lists in order;
// the single-port link memory is then written one link word per cycle.
// The result register lets the next request be taken while a result waits;
// while out_stall holds, the block finishes its current request and then
// waits with in_stall high. Synchronous reset (rst_n low) empties all class
// lists and the pool, restores the register defaults and clears claimed bytes.
// The link memory needs no clearing. cfg_we writes register cfg_index (0 heap_start,
// 1 heap_end, 2 refill_count); the user must do so only while idle, not enforced.
`timescale 1ns / 1ps
`default_nettype none
`include "size_class_pool_allocator_core_macros.svh"

module size_class_pool_allocator_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire scpa_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output scpa_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [16:0]         cfg_wdata
);

  scpa_pkg::state_t state_r, state_nxt;

  logic [15:0] heads_r [scpa_pkg::NUM_CLASSES];
  logic [15:0] heads_nxt [scpa_pkg::NUM_CLASSES];

  logic [16:0] heap_end_r;
  logic [5:0]  refill_r;
  logic [16:0] pool_start_r, pool_start_nxt;
  logic [16:0] pool_end_r, pool_end_nxt;
  logic [16:0] heap_top_r, heap_top_nxt;
  logic [16:0] claimed_r, claimed_nxt;

  logic                        op_r;
  logic                        big_r;
  logic [scpa_pkg::CLASS_W-1:0] cls_r;
  logic [15:0]                 addr_r;
  logic [7:0]                  bytes_r, bytes_nxt;
  logic [5:0]                  n_r, n_nxt;
  logic [12:0]                 bn_r, bn_nxt;
  logic [16:0]                 chunk_r, chunk_nxt;
  logic [12:0]                 acc_r, acc_nxt;
  logic [5:0]                  k_r, k_nxt;
  logic [4:0]                  srch_r, srch_nxt;
  logic [5:0]                  lnk_cnt_r, lnk_cnt_nxt;
  logic [16:0]                 lnk_addr_r, lnk_addr_nxt;
  logic [2:0]                  res_status_r, res_status_nxt;
  logic [15:0]                 res_addr_r, res_addr_nxt;

  logic                        out_valid_r;
  scpa_pkg::out_item_t         out_item_r;

  scpa_pkg::lm_req_t           lm_req;
  logic [15:0]                 lm_rdata;

  logic        in_xfer;
  logic        out_free;
  logic [15:0] in_size;
  logic [15:0] in_size_m1;
  logic [16:0] freesz;
  logic [16:0] lim;
  logic [13:0] claim_q;
  logic [16:0] claim_pad;
  logic [16:0] grow;
  logic        grow_ok;
  logic [15:0] head_cls;
  logic [15:0] head_srch;
  logic        fit_more;
  logic [16:0] round_start;

  scpa_link_mem u_link_mem (
    .clk   (clk),
    .req   (lm_req),
    .rdata (lm_rdata)
  );

  assign in_stall  = (state_r != scpa_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Size zero behaves as one granule.
  assign in_size    = (in_item.size_bytes == 16'd0) ? 16'(scpa_pkg::GRANULE)
                                                    : in_item.size_bytes;
  assign in_size_m1 = in_size - 16'd1;

  assign freesz    = (pool_end_r > pool_start_r) ? (pool_end_r - pool_start_r) : 17'd0;
  assign lim       = (heap_end_r < scpa_pkg::HEAP_BYTES) ? heap_end_r : scpa_pkg::HEAP_BYTES;
  assign claim_q   = ({1'b0, claimed_r[16:4]} + 14'd7) >> 3;
  assign claim_pad = {claim_q, 3'b000};
  assign grow      = {3'b000, bn_r, 1'b0} + claim_pad;
  assign grow_ok   = (heap_top_r < lim) && ((lim - heap_top_r) >= grow);
  assign head_cls  = heads_r[cls_r];
  assign head_srch = heads_r[srch_r[scpa_pkg::CLASS_W-1:0]];
  assign fit_more  = (k_r < n_r) && ({4'b0000, acc_r} + {9'd0, bytes_r} <= freesz);

  assign round_start = {14'((17'(cfg_wdata[15:0]) + 17'd7) >> 3), 3'b000};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scpa_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = scpa_pkg::S_DECODE;
      end
      scpa_pkg::S_DECODE: begin
        if (op_r == scpa_pkg::OP_FREE || big_r) state_nxt = scpa_pkg::S_DONE;
        else if (head_cls != 16'd0) state_nxt = scpa_pkg::S_POP;
        else state_nxt = scpa_pkg::S_REF0;
      end
      scpa_pkg::S_POP: state_nxt = scpa_pkg::S_DONE;
      scpa_pkg::S_REF0: begin
        if (freesz != 17'd0 && freesz >= {9'd0, bytes_r}) state_nxt = scpa_pkg::S_FIT;
        else state_nxt = scpa_pkg::S_GROW;
      end
      scpa_pkg::S_GROW: begin
        state_nxt = grow_ok ? scpa_pkg::S_LINK : scpa_pkg::S_SRCH;
      end
      scpa_pkg::S_SRCH: begin
        if (srch_r == 5'(scpa_pkg::NUM_CLASSES)) state_nxt = scpa_pkg::S_DONE;
        else if (head_srch != 16'd0) state_nxt = scpa_pkg::S_STEAL;
      end
      scpa_pkg::S_STEAL: begin
        state_nxt = (freesz < {9'd0, bytes_r}) ? scpa_pkg::S_DONE : scpa_pkg::S_FIT;
      end
      scpa_pkg::S_FIT: begin
        if (!fit_more) state_nxt = scpa_pkg::S_LINK;
      end
      scpa_pkg::S_LINK: begin
        if (lnk_cnt_r >= n_r) state_nxt = scpa_pkg::S_DONE;
      end
      scpa_pkg::S_DONE: begin
        if (out_free) state_nxt = scpa_pkg::S_IDLE;
      end
      default: state_nxt = scpa_pkg::S_IDLE;
    endcase
  end

  // Datapath and link memory requests.
  always_comb begin
    heads_nxt      = heads_r;
    pool_start_nxt = pool_start_r;
    pool_end_nxt   = pool_end_r;
    heap_top_nxt   = heap_top_r;
    claimed_nxt    = claimed_r;
    bytes_nxt      = bytes_r;
    n_nxt          = n_r;
    bn_nxt         = bn_r;
    chunk_nxt      = chunk_r;
    acc_nxt        = acc_r;
    k_nxt          = k_r;
    srch_nxt       = srch_r;
    lnk_cnt_nxt    = lnk_cnt_r;
    lnk_addr_nxt   = lnk_addr_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    lm_req         = '0;

    unique case (state_r)
      scpa_pkg::S_IDLE: begin
        res_addr_nxt = 16'd0;
      end
      scpa_pkg::S_DECODE: begin
        bytes_nxt = {({1'b0, cls_r} + 5'd1), 3'b000};
        if (refill_r == 6'd0) n_nxt = 6'd1;
        else if (refill_r > 6'd32) n_nxt = 6'd32;
        else n_nxt = refill_r;
        if (op_r == scpa_pkg::OP_FREE) begin
          if (addr_r == 16'd0) begin
            res_status_nxt = scpa_pkg::ST_NULL;
          end else if (big_r) begin
            res_status_nxt = scpa_pkg::ST_BIG;
          end else begin
            lm_req.we       = 1'b1;
            lm_req.waddr    = addr_r[15:3];
            lm_req.wdata    = head_cls;
            heads_nxt[cls_r] = addr_r;
            res_status_nxt  = scpa_pkg::ST_FREED;
          end
        end else if (big_r) begin
          res_status_nxt = scpa_pkg::ST_BIG;
        end else if (head_cls != 16'd0) begin
          lm_req.re    = 1'b1;
          lm_req.raddr = head_cls[15:3];
        end
      end
      scpa_pkg::S_POP: begin
        res_addr_nxt     = head_cls;
        heads_nxt[cls_r] = lm_rdata;
        res_status_nxt   = scpa_pkg::ST_ALLOC;
      end
      scpa_pkg::S_REF0: begin
        bn_nxt = 13'(bytes_r * n_r);
        if (freesz != 17'd0 && freesz < {9'd0, bytes_r}) begin
          // A leftover too small for this class goes onto its own list.
          lm_req.we    = 1'b1;
          lm_req.waddr = pool_start_r[15:3];
          lm_req.wdata = heads_r[freesz[6:3] - {3'd0, freesz[2:0] == 3'd0}];
          heads_nxt[freesz[6:3] - {3'd0, freesz[2:0] == 3'd0}] = pool_start_r[15:0];
          pool_start_nxt = 17'd0;
          pool_end_nxt   = 17'd0;
        end else if (freesz != 17'd0) begin
          chunk_nxt = pool_start_r;
          acc_nxt   = 13'd0;
          k_nxt     = 6'd0;
        end
      end
      scpa_pkg::S_GROW: begin
        srch_nxt = {1'b0, cls_r} + 5'd1;
        if (grow_ok) begin
          chunk_nxt      = heap_top_r;
          heap_top_nxt   = heap_top_r + grow;
          claimed_nxt    = claimed_r + grow;
          pool_start_nxt = heap_top_r + {4'd0, bn_r};
          pool_end_nxt   = heap_top_r + grow;
          lnk_cnt_nxt    = 6'd1;
          lnk_addr_nxt   = heap_top_r + {9'd0, bytes_r};
        end
      end
      scpa_pkg::S_SRCH: begin
        if (srch_r == 5'(scpa_pkg::NUM_CLASSES)) begin
          res_status_nxt = scpa_pkg::ST_OOM;
        end else if (head_srch != 16'd0) begin
          lm_req.re      = 1'b1;
          lm_req.raddr   = head_srch[15:3];
          pool_start_nxt = {1'b0, head_srch};
          pool_end_nxt   = {1'b0, head_srch} + {9'd0, srch_r + 5'd1, 3'b000};
        end else begin
          srch_nxt = srch_r + 5'd1;
        end
      end
      scpa_pkg::S_STEAL: begin
        heads_nxt[srch_r[scpa_pkg::CLASS_W-1:0]] = lm_rdata;
        chunk_nxt = pool_start_r;
        acc_nxt   = 13'd0;
        k_nxt     = 6'd0;
        if (freesz < {9'd0, bytes_r}) res_status_nxt = scpa_pkg::ST_OOM;
      end
      scpa_pkg::S_FIT: begin
        if (fit_more) begin
          k_nxt   = k_r + 6'd1;
          acc_nxt = acc_r + {5'd0, bytes_r};
        end else begin
          n_nxt          = k_r;
          pool_start_nxt = pool_start_r + {4'd0, acc_r};
          lnk_cnt_nxt    = 6'd1;
          lnk_addr_nxt   = chunk_r + {9'd0, bytes_r};
        end
      end
      scpa_pkg::S_LINK: begin
        if (lnk_cnt_r < n_r) begin
          lm_req.we    = 1'b1;
          lm_req.waddr = lnk_addr_r[15:3];
          lm_req.wdata = (lnk_cnt_r == n_r - 6'd1) ? 16'd0
                                                   : 16'(lnk_addr_r + {9'd0, bytes_r});
          lnk_cnt_nxt  = lnk_cnt_r + 6'd1;
          lnk_addr_nxt = lnk_addr_r + {9'd0, bytes_r};
        end else begin
          if (n_r > 6'd1) heads_nxt[cls_r] = 16'(chunk_r + {9'd0, bytes_r});
          res_addr_nxt   = chunk_r[15:0];
          // A run that starts where addresses wrap to zero reads as null.
          res_status_nxt = (chunk_r[15:0] != 16'd0) ? scpa_pkg::ST_ALLOC
                                                    : scpa_pkg::ST_OOM;
        end
      end
      scpa_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase

    // The user must send configuration writes only while idle; not enforced.
    if (cfg_we && cfg_index == scpa_pkg::REG_HEAP_START) begin
      heap_top_nxt = (round_start < 17'(scpa_pkg::GRANULE)) ? 17'(scpa_pkg::GRANULE)
                                                             : round_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scpa_pkg::S_IDLE;
      heads_r      <= '{default: 16'd0};
      pool_start_r <= 17'd0;
      pool_end_r   <= 17'd0;
      heap_top_r   <= 17'(scpa_pkg::GRANULE);
      claimed_r    <= 17'd0;
      heap_end_r   <= scpa_pkg::HEAP_BYTES;
      refill_r     <= 6'd20;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      heads_r      <= heads_nxt;
      pool_start_r <= pool_start_nxt;
      pool_end_r   <= pool_end_nxt;
      heap_top_r   <= heap_top_nxt;
      claimed_r    <= claimed_nxt;
      if (cfg_we && cfg_index == scpa_pkg::REG_HEAP_END) heap_end_r <= cfg_wdata;
      if (cfg_we && cfg_index == scpa_pkg::REG_REFILL_COUNT) refill_r <= cfg_wdata[5:0];
      if (state_r == scpa_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_item.opcode;
      big_r  <= (in_size_m1 >= scpa_pkg::MAX_BLOCK);
      cls_r  <= in_size_m1[6:3];
      addr_r <= in_item.free_addr;
    end
    bytes_r      <= bytes_nxt;
    n_r          <= n_nxt;
    bn_r         <= bn_nxt;
    chunk_r      <= chunk_nxt;
    acc_r        <= acc_nxt;
    k_r          <= k_nxt;
    srch_r       <= srch_nxt;
    lnk_cnt_r    <= lnk_cnt_nxt;
    lnk_addr_r   <= lnk_addr_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    if (state_r == scpa_pkg::S_DONE && out_free) begin
      out_item_r.status        <= res_status_r;
      out_item_r.block_addr    <= res_addr_r;
      out_item_r.claimed_bytes <= claimed_r;
    end
  end

  `SCPA_ASSERT_NEXT(a_accept_decodes, in_xfer, state_r == scpa_pkg::S_DECODE,
                    "accepted transfer did not enter decode")
  `SCPA_ASSERT_NOW(a_link_count, state_r == scpa_pkg::S_LINK, lnk_cnt_r <= n_r,
                   "link chain counter ran past the block count")
  `SCPA_ASSERT_NOW(a_result_source, $rose(out_valid_r), $past(state_r) == scpa_pkg::S_DONE,
                   "result appeared without a finished request")
  `SCPA_ASSERT_NOW(a_alloc_nonnull,
                   out_valid_r && out_item_r.status == scpa_pkg::ST_ALLOC,
                   out_item_r.block_addr != 16'd0,
                   "allocation returned a null address")

endmodule

`default_nettype wire
